@@ src/ifp_pkg.sv @@
package ifp_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int CODE_W          = 3;
  localparam int CHAR_W          = 8;

  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_ADD   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SUB   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;

  typedef enum logic [CODE_W-1:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_code_t;

  typedef enum logic [1:0] {
    ST_CHAR      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNMATCHED = 2'd2,
    ST_END       = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OP_CHK,
    S_OP_PUSH,
    S_CL_CHK,
    S_CL_UNM,
    S_FL_START,
    S_FL_CHK,
    S_FL_END,
    S_DONE
  } state_t;

  function automatic logic is_alnum(input logic [CHAR_W-1:0] ch);
    return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
           (ch >= 8'h61 && ch <= 8'h7A);
  endfunction

  function automatic logic is_arith(input logic [CHAR_W-1:0] ch);
    return (ch == CH_ADD) || (ch == CH_SUB) || (ch == CH_MUL) || (ch == CH_DIV);
  endfunction

  function automatic op_code_t to_code(input logic [CHAR_W-1:0] ch);
    op_code_t c;
    c = OP_OPEN;
    if (ch == CH_ADD) c = OP_ADD;
    else if (ch == CH_SUB) c = OP_SUB;
    else if (ch == CH_MUL) c = OP_MUL;
    else if (ch == CH_DIV) c = OP_DIV;
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] code_char(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] c;
    unique case (code)
      OP_OPEN: c = CH_OPEN;
      OP_ADD:  c = CH_ADD;
      OP_SUB:  c = CH_SUB;
      OP_MUL:  c = CH_MUL;
      OP_DIV:  c = CH_DIV;
      default: c = '0;
    endcase
    return c;
  endfunction

  // multiply and divide bind tighter than add and subtract
  function automatic logic is_heavy(input logic [CODE_W-1:0] code);
    return code >= OP_MUL;
  endfunction

endpackage

@@ src/ifp_ram.sv @@
module ifp_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/infix_to_postfix_converter_top.sv @@
// Channel  Direction  Handshake          Payload
// in_      slave      in_tvalid/tready   in_tdata = character, in_tlast = end of expression
// out_     master     out_tvalid/tready  out_tdata = character, out_tuser = status,
//                                        out_tlast = last word of this input
// A letter, digit, '(' or ignored character is taken in the idle state; ')' pops entries down to its '('.
// An operator pops entries of equal or tighter binding down to the nearest '(', then is pushed.
// End of expression pops and emits every stack entry, dropping '(' entries, then emits the end marker.
// The stack sits in a single-read-port RAM with registered read, one entry per cycle unless the output stalls.
// Reset clears the stack count only; no clearing pass over the RAM.
// One word is held back to mark the last of a run; the sequencer holds when another
// word is due while the output register is still full.
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = ifp_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,   // end_of_expr
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [1:0] out_tuser,  // [1:0] status
  output logic       out_tlast   // last_of_run
);

  import ifp_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  op_code_t          op_r, op_nxt;
  logic              last_r, last_nxt;

  logic              pend_valid_r, pend_valid_nxt;
  logic [CHAR_W-1:0] pend_char_r, pend_char_nxt;
  status_t           pend_status_r, pend_status_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CODE_W-1:0] ram_wdata, ram_rdata;

  logic              emit_new, flush_pend, out_load;
  logic [CHAR_W-1:0] new_char;
  status_t           new_status;
  logic              out_free, can_go, full, top_open, top_pops;
  logic [CW-1:0]     cnt_m1, cnt_m2;
  state_t            after_st, after_in;
  logic [CHAR_W-1:0] ch;

  ifp_ram #(
    .WIDTH (CODE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_tready;
  assign can_go   = !pend_valid_r || out_free;
  assign full     = (count_r == CW'(STACK_DEPTH));
  assign cnt_m1   = count_r - CW'(1);
  assign cnt_m2   = count_r - CW'(2);
  assign top_open = (ram_rdata == OP_OPEN);
  assign top_pops = !top_open && (is_heavy(ram_rdata) || !is_heavy(op_r));
  assign after_st = last_r ? S_FL_START : S_DONE;
  assign after_in = in_tlast ? S_FL_START : S_DONE;
  assign ch       = in_tdata;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    op_nxt     = op_r;
    last_nxt   = last_r;
    emit_new   = 1'b0;
    flush_pend = 1'b0;
    new_char   = '0;
    new_status = ST_CHAR;
    ram_we     = 1'b0;
    ram_waddr  = count_r[AW-1:0];
    ram_wdata  = OP_OPEN;
    ram_raddr  = cnt_m1[AW-1:0];
    in_tready  = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          last_nxt = in_tlast;
          priority if (is_alnum(ch)) begin
            emit_new  = 1'b1;
            new_char  = ch;
            state_nxt = after_in;
          end else if (ch == CH_OPEN) begin
            if (full) begin
              emit_new   = 1'b1;
              new_status = ST_OVERFLOW;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = OP_OPEN;
              count_nxt = count_r + CW'(1);
            end
            state_nxt = after_in;
          end else if (is_arith(ch)) begin
            op_nxt    = to_code(ch);
            state_nxt = (count_r == '0) ? S_OP_PUSH : S_OP_CHK;
          end else if (ch == CH_CLOSE) begin
            state_nxt = (count_r == '0) ? S_CL_UNM : S_CL_CHK;
          end else begin
            state_nxt = after_in;
          end
        end
      end

      S_OP_CHK: begin
        if (top_pops) begin
          if (can_go) begin
            emit_new  = 1'b1;
            new_char  = code_char(ram_rdata);
            count_nxt = cnt_m1;
            ram_raddr = cnt_m2[AW-1:0];
            if (cnt_m1 == '0) state_nxt = S_OP_PUSH;
          end
        end else begin
          state_nxt = S_OP_PUSH;
        end
      end

      S_OP_PUSH: begin
        if (full) begin
          if (can_go) begin
            emit_new   = 1'b1;
            new_status = ST_OVERFLOW;
            state_nxt  = after_st;
          end
        end else begin
          ram_we    = 1'b1;
          ram_wdata = op_r;
          count_nxt = count_r + CW'(1);
          state_nxt = after_st;
        end
      end

      S_CL_CHK: begin
        if (top_open) begin
          // drop the matching open paren
          count_nxt = cnt_m1;
          state_nxt = after_st;
        end else if (can_go) begin
          emit_new  = 1'b1;
          new_char  = code_char(ram_rdata);
          count_nxt = cnt_m1;
          ram_raddr = cnt_m2[AW-1:0];
          if (cnt_m1 == '0) state_nxt = S_CL_UNM;
        end
      end

      S_CL_UNM: begin
        if (can_go) begin
          emit_new   = 1'b1;
          new_status = ST_UNMATCHED;
          state_nxt  = after_st;
        end
      end

      S_FL_START: begin
        state_nxt = (count_r == '0) ? S_FL_END : S_FL_CHK;
      end

      S_FL_CHK: begin
        if (top_open || can_go) begin
          if (!top_open) begin
            emit_new = 1'b1;
            new_char = code_char(ram_rdata);
          end
          count_nxt = cnt_m1;
          ram_raddr = cnt_m2[AW-1:0];
          if (cnt_m1 == '0) state_nxt = S_FL_END;
        end
      end

      S_FL_END: begin
        if (can_go) begin
          emit_new   = 1'b1;
          new_status = ST_END;
          state_nxt  = S_DONE;
        end
      end

      S_DONE: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          flush_pend = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold one word back so the last word of a run can be marked
  always_comb begin
    pend_valid_nxt  = pend_valid_r;
    pend_char_nxt   = pend_char_r;
    pend_status_nxt = pend_status_r;
    out_load        = 1'b0;
    out_char_nxt    = out_char_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;

    if (emit_new) begin
      if (pend_valid_r) begin
        out_load       = 1'b1;
        out_char_nxt   = pend_char_r;
        out_status_nxt = pend_status_r;
        out_last_nxt   = 1'b0;
      end
      pend_valid_nxt  = 1'b1;
      pend_char_nxt   = new_char;
      pend_status_nxt = new_status;
    end else if (flush_pend) begin
      out_load       = 1'b1;
      out_char_nxt   = pend_char_r;
      out_status_nxt = pend_status_r;
      out_last_nxt   = 1'b1;
      pend_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_load ? 1'b1 : (out_free ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    last_r        <= last_nxt;
    pend_char_r   <= pend_char_nxt;
    pend_status_r <= pend_status_nxt;
    out_char_r    <= out_char_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  a_ready_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pend_valid_r)
    else $error("input accepted while a word is still held back");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_END) |-> out_tlast)
    else $error("end marker not last word of its run");

  a_status_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_CHAR) |-> (out_tdata == '0))
    else $error("status word carries a character");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !pend_valid_r) |=> in_tready)
    else $error("sequencer failed to return to idle");

endmodule

@@ tb/postfix_checker.sv @@
module postfix_checker
  import ifp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic [1:0] out_tuser,
  input  logic       out_tlast,
  output int         fail_count,
  output int         words_due,
  output int         words_checked,
  output int         overflow_seen,
  output int         unmatched_seen,
  output int         end_marks
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    status_t    st;
    logic       last;
  } post_word_t;

  localparam logic [7:0] OP_SYMBOL [5] = '{CH_OPEN, CH_ADD, CH_SUB, CH_MUL, CH_DIV};

  op_code_t   op_stack [STACK_DEPTH];
  int         stack_used;
  post_word_t postfix_due [$];
  post_word_t run_words [$];

  function automatic void emit(input logic [7:0] ch, input status_t st);
    post_word_t w;
    w.ch   = ch;
    w.st   = st;
    w.last = 1'b0;
    run_words.push_back(w);
  endfunction

  function automatic logic binds_tight(input op_code_t op);
    return (op == OP_MUL) || (op == OP_DIV);
  endfunction

  function automatic void push_op(input op_code_t op);
    if (stack_used >= STACK_DEPTH) begin
      emit(8'h00, ST_OVERFLOW);
    end else begin
      op_stack[stack_used] = op;
      stack_used++;
    end
  endfunction

  function automatic void pop_op();
    stack_used--;
    emit(OP_SYMBOL[op_stack[stack_used]], ST_CHAR);
  endfunction

  // pop equal or tighter operators down to the nearest '(', then stack the new one
  function automatic void take_operator(input op_code_t op);
    while (stack_used > 0 && op_stack[stack_used-1] != OP_OPEN &&
           binds_tight(op_stack[stack_used-1]) >= binds_tight(op))
      pop_op();
    push_op(op);
  endfunction

  function automatic void predict_postfix(input logic [7:0] ch, input logic eoe);
    run_words = {};
    if ((ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
        (ch >= 8'h61 && ch <= 8'h7A)) begin
      emit(ch, ST_CHAR);
    end else begin
      case (ch)
        CH_OPEN:  push_op(OP_OPEN);
        CH_ADD:   take_operator(OP_ADD);
        CH_SUB:   take_operator(OP_SUB);
        CH_MUL:   take_operator(OP_MUL);
        CH_DIV:   take_operator(OP_DIV);
        CH_CLOSE: begin
          while (stack_used > 0 && op_stack[stack_used-1] != OP_OPEN)
            pop_op();
          if (stack_used > 0) stack_used--;
          else emit(8'h00, ST_UNMATCHED);
        end
        default: ;
      endcase
    end
    if (eoe) begin
      // leftover '(' entries vanish silently
      while (stack_used > 0) begin
        if (op_stack[stack_used-1] == OP_OPEN) stack_used--;
        else pop_op();
      end
      emit(8'h00, ST_END);
    end
    if (run_words.size() > 0) run_words[run_words.size()-1].last = 1'b1;
    foreach (run_words[i]) postfix_due.push_back(run_words[i]);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  function automatic void check_word();
    post_word_t exp;
    words_checked++;
    case (out_tuser)
      ST_OVERFLOW:  overflow_seen++;
      ST_UNMATCHED: unmatched_seen++;
      ST_END:       end_marks++;
      default: ;
    endcase
    if (postfix_due.size() == 0) begin
      note_failure($sformatf("unexpected word: char %02h status %0d last %0b",
                             out_tdata, out_tuser, out_tlast));
    end else begin
      exp = postfix_due.pop_front();
      if (out_tdata !== exp.ch || out_tuser !== exp.st || out_tlast !== exp.last)
        note_failure($sformatf(
          "word mismatch: expected char %02h status %0d last %0b, got %02h %0d %0b",
          exp.ch, exp.st, exp.last, out_tdata, out_tuser, out_tlast));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      postfix_due.delete();
      stack_used = 0;
    end else begin
      if (in_tvalid && in_tready) predict_postfix(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_word();
    end
    words_due = postfix_due.size();
  end

endmodule

@@ tb/tb_infix_to_postfix_converter_top.sv @@
module tb_infix_to_postfix_converter_top;
  import ifp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {PACE_FULL, PACE_RANDOM, PACE_PERIODIC, PACE_STALLS} pace_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  int fail_count, words_due, words_checked, overflow_seen, unmatched_seen, end_marks;

  int         burst_left;
  int         words_sent;
  int         stray_sent;
  logic [7:0] expr_text [$];

  pace_t pace_mode;
  int    pace_left;
  int    stall_left;

  infix_to_postfix_converter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  postfix_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .words_due      (words_due),
    .words_checked  (words_checked),
    .overflow_seen  (overflow_seen),
    .unmatched_seen (unmatched_seen),
    .end_marks      (end_marks)
  );

  always #5 clk = ~clk;

  // receiver: pick a new random pacing mode whenever the current one runs out
  always @(negedge clk) begin
    if (pace_left == 0) begin
      pace_mode = pace_t'($urandom_range(0, 3));
      pace_left = $urandom_range(30, 120);
    end
    pace_left--;
    case (pace_mode)
      PACE_FULL:     out_tready = 1'b1;
      PACE_RANDOM:   out_tready = ($urandom_range(0, 9) < 7);
      PACE_PERIODIC: out_tready = (pace_left % 4 != 0);
      default: begin
        if (stall_left > 0) begin
          out_tready = 1'b0;
          stall_left--;
        end else begin
          out_tready = 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(3, 12);
        end
      end
    endcase
  end

  // call and return just after a falling edge
  task automatic send_word(input logic [7:0] ch, input logic eoe);
    if (burst_left <= 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_tvalid = 1'b1;
    in_tdata  = ch;
    in_tlast  = eoe;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    burst_left--;
    words_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (words_due != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 2))
      0:       return 8'h30 + 8'($urandom_range(0, 9));
      1:       return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  // mostly well-formed expressions; some nest deep enough to fill the stack,
  // some leave brackets open, close too many or insert an extra operator
  task automatic build_expr();
    int   n_terms;
    int   open_now;
    logic deep;
    logic broken;
    expr_text = {};
    open_now  = 0;
    deep      = ($urandom_range(0, 11) == 0);
    broken    = ($urandom_range(0, 6) == 0);
    n_terms   = deep ? $urandom_range(1, 4) : $urandom_range(1, 7);
    if (deep) begin
      repeat ($urandom_range(14, 18)) begin
        expr_text.push_back(CH_OPEN);
        open_now++;
      end
    end
    for (int t = 0; t < n_terms; t++) begin
      if (t > 0) expr_text.push_back(pick_op());
      while ($urandom_range(0, 3) == 0) begin
        expr_text.push_back(CH_OPEN);
        open_now++;
      end
      expr_text.push_back(pick_operand());
      while (open_now > 0 && $urandom_range(0, 2) == 0) begin
        expr_text.push_back(CH_CLOSE);
        open_now--;
      end
      if ($urandom_range(0, 9) == 0) begin
        expr_text.push_back(($urandom_range(0, 1) == 0) ? 8'h20 : 8'($urandom_range(0, 255)));
        stray_sent++;
      end
    end
    if (!broken) begin
      repeat (open_now) expr_text.push_back(CH_CLOSE);
    end else begin
      case ($urandom_range(0, 2))
        0: ;
        1: repeat (open_now + $urandom_range(1, 2)) expr_text.push_back(CH_CLOSE);
        default: expr_text.insert($urandom_range(0, expr_text.size()), pick_op());
      endcase
    end
  endtask

  initial begin
    string directed;
    int    random_base;
    directed = "a+B*9-z/0";
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_word(8'h00, 1'b0);
    for (int i = 0; i < directed.len(); i++) send_word(directed[i], 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(CH_CLOSE, 1'b1);
    repeat (16) send_word(CH_OPEN, 1'b0);
    send_word(CH_MUL, 1'b0);
    send_word(CH_CLOSE, 1'b1);
    wait_drained();

    random_base = words_sent;
    while (words_sent - stray_sent - random_base < 260) begin
      build_expr();
      foreach (expr_text[i]) send_word(expr_text[i], i == expr_text.size() - 1);
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (100) @(negedge clk);
    $display("Sent %0d input words (%0d stray bytes), checked %0d output words.",
             words_sent, stray_sent, words_checked);
    $display("Saw %0d stack overflows, %0d unmatched closing brackets, %0d expression ends.",
             overflow_seen, unmatched_seen, end_marks);
    if (fail_count == 0 && words_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
